/* rtl/bmsd_pkg.sv */
// Shared types and constants for the stereo block-matching disparity core.
// No dependencies.
package bmsd_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxWindow  = 15;
  localparam int MaxDisp    = 64;
  localparam int PixBits    = 8;
  localparam int Channels   = 3;
  localparam int ColBits    = 10;
  localparam int RowBits    = 12;
  localparam int SlotBits   = 4;
  localparam int DispBits   = 6;
  localparam int CostBits   = 26;
  localparam int AddrBits   = SlotBits + ColBits;
  localparam int WordBits   = PixBits * Channels;
  localparam int StepBits   = 7;

  localparam logic [2:0] RegWidth   = 3'd0;
  localparam logic [2:0] RegHeight  = 3'd1;
  localparam logic [2:0] RegHalfH   = 3'd2;
  localparam logic [2:0] RegHalfW   = 3'd3;
  localparam logic [2:0] RegMaxDisp = 3'd4;
  localparam logic [2:0] RegChans   = 3'd5;
  localparam logic [2:0] RegMode    = 3'd6;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_MIN   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic acc;
    logic drain;
    logic sad;
  } cell_ctl_t;

endpackage

/* rtl/bmsd_line_store.sv */
// Line store: window rows of one image, one word holds all channels of a pixel.
// Uses bmsd_pkg.
module bmsd_line_store (
  input  logic                                clk,
  input  logic                                we,
  input  logic [bmsd_pkg::AddrBits-1:0]       waddr,
  input  logic [bmsd_pkg::WordBits-1:0]       wdata,
  input  logic [bmsd_pkg::AddrBits-1:0]       raddr,
  output logic [bmsd_pkg::WordBits-1:0]       rdata
);

  logic [bmsd_pkg::WordBits-1:0] mem [2**bmsd_pkg::AddrBits];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bmsd_cell.sv */
// One disparity cell: holds a delayed right pixel and the window cost.
// Uses bmsd_pkg.
module bmsd_cell (
  input  logic                                clk,
  input  bmsd_pkg::cell_ctl_t                 ctl,
  input  logic [bmsd_pkg::PixBits-1:0]        left_pix,
  input  logic [bmsd_pkg::PixBits-1:0]        r_in,
  input  logic [bmsd_pkg::CostBits-1:0]       acc_in,
  output logic [bmsd_pkg::PixBits-1:0]        r_out,
  output logic [bmsd_pkg::CostBits-1:0]       acc_out
);

  logic [bmsd_pkg::PixBits-1:0]   diff;
  logic [2*bmsd_pkg::PixBits-1:0] term;

  always_comb begin
    diff = (left_pix > r_in) ? left_pix - r_in : r_in - left_pix;
    term = ctl.sad ? {{bmsd_pkg::PixBits{1'b0}}, diff} : diff * diff;
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      r_out <= r_in;
    end
    if (ctl.clear) begin
      acc_out <= '0;
    end else if (ctl.acc) begin
      acc_out <= acc_out + bmsd_pkg::CostBits'(term);
    end else if (ctl.drain) begin
      acc_out <= acc_in;
    end
  end

endmodule

/* rtl/block_match_stereo_disparity_core.sv */
// Top level of the stereo block-matching disparity core.
// Uses bmsd_pkg, bmsd_line_store and bmsd_cell.
//
// Input words arrive on s_* (tuser = start of frame, tdata = left and right
// pixels); one disparity word per interior pixel leaves on m_*. Registers are
// written through cfg_* (always ready); the user must write them only while the
// core is idle, the core itself does not enforce this. A pixel that completes no
// window is only stored. A pixel that completes a window is scanned over each window
// row, channel and column, then drained, searched and output. The scan is set by
// the single read port of each line store: one pixel column per cycle is
// shifted down a chain of 64 disparity cells, each accumulating its cost.
// The output register holds a finished word while the next pixel is taken;
// if the receiver stalls and a second result is ready, the core waits.
// Reset clears counters, registers to defaults and the output valid. Line
// stores are not cleared; every entry read in a frame is written first.
module block_match_stereo_disparity_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // left_ch0, left_ch1, left_ch2, right_ch0, right_ch1, right_ch2
  input  logic        s_tuser,   // start_of_frame
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // disparity, out_col, out_row, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int ND = bmsd_pkg::MaxDisp;
  localparam int PB = bmsd_pkg::PixBits;

  // configuration
  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [2:0]  half_h, half_w;
  logic [5:0]  max_disp;
  logic [1:0]  chans;
  logic        cost_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd640;
      frame_height <= 13'd480;
      half_h       <= 3'd2;
      half_w       <= 3'd2;
      max_disp     <= 6'd63;
      chans        <= 2'd1;
      cost_mode    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bmsd_pkg::RegWidth:   frame_width  <= cfg_data[10:0];
        bmsd_pkg::RegHeight:  frame_height <= cfg_data;
        bmsd_pkg::RegHalfH:   half_h       <= cfg_data[2:0];
        bmsd_pkg::RegHalfW:   half_w       <= cfg_data[2:0];
        bmsd_pkg::RegMaxDisp: max_disp     <= cfg_data[5:0];
        bmsd_pkg::RegChans:   chans        <= cfg_data[1:0];
        bmsd_pkg::RegMode:    cost_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [10:0] eff_w;
  logic [12:0] eff_h;
  logic [1:0]  eff_nch;

  always_comb begin
    eff_w = frame_width;
    if (eff_w == 11'd0) eff_w = 11'd1;
    if (eff_w > 11'd1024) eff_w = 11'd1024;
    eff_h = frame_height;
    if (eff_h == 13'd0) eff_h = 13'd1;
    if (eff_h > 13'd4096) eff_h = 13'd4096;
    eff_nch = (chans == 2'd0) ? 2'd1 : chans;
  end

  // raster counters
  logic [bmsd_pkg::ColBits-1:0]  col;
  logic [bmsd_pkg::RowBits-1:0]  row;
  logic [bmsd_pkg::SlotBits-1:0] slot;

  logic [10:0] c0, c1;
  logic [12:0] r0, r1;
  logic [3:0]  s0, s1;
  logic        emit;
  logic [9:0]  c_span;
  logic [5:0]  dm_new;
  logic [4:0]  slot_sum;
  logic [3:0]  win_slot_new;

  function automatic logic [3:0] slot_inc(input logic [3:0] s);
    return (s == 4'(bmsd_pkg::MaxWindow - 1)) ? 4'd0 : s + 4'd1;
  endfunction

  always_comb begin
    c0 = s_tuser ? 11'd0 : {1'b0, col};
    r0 = s_tuser ? 13'd0 : {1'b0, row};
    s0 = s_tuser ? 4'd0 : slot;
    if (c0 >= eff_w) begin
      c0 = 11'd0;
      r0 = r0 + 13'd1;
      s0 = slot_inc(s0);
    end
    if (r0 >= eff_h) begin
      r0 = 13'd0;
      s0 = 4'd0;
    end
    c1 = c0 + 11'd1;
    r1 = r0;
    s1 = s0;
    if (c1 >= eff_w) begin
      c1 = 11'd0;
      r1 = r0 + 13'd1;
      s1 = slot_inc(s0);
      if (r1 >= eff_h) begin
        r1 = 13'd0;
        s1 = 4'd0;
      end
    end
    emit   = (r0 >= {9'd0, half_h, 1'b0}) && (c0 >= {7'd0, half_w, 1'b0});
    c_span = c0[9:0] - {6'd0, half_w, 1'b0};
    dm_new = (c_span < {4'd0, max_disp}) ? c_span[5:0] : max_disp;
    slot_sum = {1'b0, s0} - {1'b0, half_h, 1'b0};
    if ({1'b0, s0} < {1'b0, half_h, 1'b0}) begin
      slot_sum = slot_sum + 5'(bmsd_pkg::MaxWindow);
    end
    win_slot_new = slot_sum[3:0];
  end

  // control
  bmsd_pkg::state_t state;
  logic accept;
  assign s_tready = (state == bmsd_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  logic [9:0]  base_col, out_x;
  logic [11:0] out_y;
  logic [5:0]  dm;
  logic [6:0]  tmax;
  logic [3:0]  hh2;
  logic [1:0]  nch_l;
  logic        sad_l;
  logic [3:0]  wy, cur_slot;
  logic [1:0]  k;
  logic [6:0]  t;
  logic [5:0]  min_d, best_d;
  logic [bmsd_pkg::CostBits-1:0] best_cost;
  logic        p_valid, p_acc;
  logic [1:0]  p_k;
  logic        scan_last;

  assign scan_last = (t == tmax) && (k == nch_l - 2'd1) && (wy == hh2);

  logic [bmsd_pkg::CostBits-1:0] acc_chain [ND+1];
  logic [PB-1:0]                 r_chain   [ND+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bmsd_pkg::ST_IDLE;
      col      <= '0;
      row      <= '0;
      slot     <= '0;
      m_tvalid <= 1'b0;
      p_valid  <= 1'b0;
    end else begin
      p_valid <= (state == bmsd_pkg::ST_RUN);
      if (state == bmsd_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        bmsd_pkg::ST_IDLE: begin
          if (accept) begin
            col  <= c1[9:0];
            row  <= r1[11:0];
            slot <= s1;
            if (emit) begin
              state <= bmsd_pkg::ST_RUN;
            end
          end
        end
        bmsd_pkg::ST_RUN: begin
          if (scan_last) state <= bmsd_pkg::ST_DRAIN;
        end
        bmsd_pkg::ST_DRAIN: state <= bmsd_pkg::ST_MIN;
        bmsd_pkg::ST_MIN: begin
          if (min_d == dm) state <= bmsd_pkg::ST_DONE;
        end
        bmsd_pkg::ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= bmsd_pkg::ST_IDLE;
          end
        end
        default: state <= bmsd_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    p_acc <= (t >= {1'b0, dm});
    p_k   <= k;
    if (accept && emit) begin
      base_col <= c_span - {4'd0, dm_new};
      out_x    <= c0[9:0] - {7'd0, half_w};
      out_y    <= r0[11:0] - {9'd0, half_h};
      dm       <= dm_new;
      tmax     <= {1'b0, dm_new} + {3'd0, half_w, 1'b0};
      hh2      <= {half_h, 1'b0};
      nch_l    <= eff_nch;
      sad_l    <= cost_mode;
      wy       <= '0;
      cur_slot <= win_slot_new;
      k        <= '0;
      t        <= '0;
      min_d    <= '0;
    end else if (state == bmsd_pkg::ST_RUN) begin
      if (t == tmax) begin
        t <= '0;
        if (k == nch_l - 2'd1) begin
          k        <= '0;
          wy       <= wy + 4'd1;
          cur_slot <= slot_inc(cur_slot);
        end else begin
          k <= k + 2'd1;
        end
      end else begin
        t <= t + 7'd1;
      end
    end else if (state == bmsd_pkg::ST_MIN) begin
      min_d <= min_d + 6'd1;
      if (min_d == 6'd0 || acc_chain[0] < best_cost) begin
        best_cost <= acc_chain[0];
        best_d    <= min_d;
      end
    end
    if (state == bmsd_pkg::ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {4'd0, out_y, out_x, best_d};
    end
  end

  // line stores
  logic [bmsd_pkg::AddrBits-1:0] waddr, raddr;
  logic [bmsd_pkg::WordBits-1:0] l_rd, r_rd;
  logic [9:0] rcol;

  assign waddr = {s0, c0[9:0]};
  assign rcol  = base_col + {3'd0, t};
  assign raddr = {cur_slot, rcol};

  bmsd_line_store u_left (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (s_tdata[23:0]),
    .raddr (raddr),
    .rdata (l_rd)
  );

  bmsd_line_store u_right (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (s_tdata[47:24]),
    .raddr (raddr),
    .rdata (r_rd)
  );

  // chain of disparity cells
  logic [PB-1:0] l_pix, r_pix;
  bmsd_pkg::cell_ctl_t ctl;

  always_comb begin
    unique case (p_k)
      2'd1:    begin l_pix = l_rd[15:8];  r_pix = r_rd[15:8];  end
      2'd2:    begin l_pix = l_rd[23:16]; r_pix = r_rd[23:16]; end
      default: begin l_pix = l_rd[7:0];   r_pix = r_rd[7:0];   end
    endcase
    ctl.clear = accept && emit;
    ctl.shift = p_valid;
    ctl.acc   = p_valid && p_acc;
    ctl.drain = (state == bmsd_pkg::ST_MIN);
    ctl.sad   = sad_l;
  end

  // cell d sees the right pixel read d scan steps earlier
  assign r_chain[0]    = r_pix;
  assign acc_chain[ND] = '0;

  for (genvar d = 0; d < ND; d++) begin : g_cell
    logic [PB-1:0] r_hold;
    bmsd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .left_pix (l_pix),
      .r_in     (r_chain[d]),
      .acc_in   (acc_chain[d+1]),
      .r_out    (r_hold),
      .acc_out  (acc_chain[d])
    );
    assign r_chain[d+1] = r_hold;
  end

  // the last tap is unused beyond the chain
  logic unused_tap;
  assign unused_tap = ^r_chain[ND];

  a_min_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bmsd_pkg::ST_MIN) |-> (min_d <= dm))
    else $error("minimum search ran past the disparity bound");

  a_pipe_src: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> $past(state == bmsd_pkg::ST_RUN))
    else $error("scan data without a scan issue");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == bmsd_pkg::ST_RUN) |-> !s_tready)
    else $error("input taken during a search");

endmodule
